### rtl/priority_queue_starvation_limit_unit_macros.svh
// Assertion macros for the job arbiter RTL.
// Included by pqsl_dp.sv; depends on nothing else.
`ifndef PRIORITY_QUEUE_STARVATION_LIMIT_UNIT_MACROS_SVH
`define PRIORITY_QUEUE_STARVATION_LIMIT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is high.
`define PQSL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define PQSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQSL_ASSERT(lbl, clk, rst, prop, msg)
`define PQSL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/pqsl_pkg.sv
// Shared types, operation codes and defaults for the job arbiter.
// Used by pqsl_ctrl, pqsl_dp and the top level; depends on nothing.
package pqsl_pkg;

  localparam int JOB_ID_W       = 16;
  localparam int FUNC_W         = 2;
  localparam int S_USER_W       = 3;
  localparam int M_USER_W       = 4;
  localparam int STREAK_W       = 8;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [STREAK_W-1:0] DEF_STREAK_LIMIT = 8'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX       = 8'hFF;

  // Operation codes carried in the low bits of s_tuser.
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic push_read;  // extract data from the queue memory is ready
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;   // result buffer holds two words
    logic is_extract; // word at the input is an extract
  } dp_status_t;

endpackage

### rtl/pqsl_ctrl.sv
// Sequencer of the job arbiter: input handshake and extract read cycle.
// Depends on pqsl_pkg.
module pqsl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  pqsl_pkg::dp_status_t   status,
  output pqsl_pkg::ctrl_cmd_t    cmd
);

  pqsl_pkg::state_t state;
  pqsl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pqsl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pqsl_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready && status.is_extract) begin
          state_next = pqsl_pkg::ST_READ;
        end
      end
      pqsl_pkg::ST_READ: begin
        state_next = pqsl_pkg::ST_IDLE;
      end
      default: begin
        state_next = pqsl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = (state == pqsl_pkg::ST_IDLE) && !status.out_full;
    cmd.accept    = s_tvalid && s_tready;
    cmd.push_read = (state == pqsl_pkg::ST_READ);
  end

endmodule

### rtl/pqsl_dp.sv
// Datapath of the job arbiter: two queue memories, pointers, streak,
// limit register and a two-word result buffer. Depends on pqsl_pkg
// and the assertion macro header.
`include "priority_queue_starvation_limit_unit_macros.svh"

module pqsl_dp #(
  parameter int QUEUE_DEPTH = pqsl_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pqsl_pkg::STREAK_W-1:0]     cfg_wr_data,
  input  logic [pqsl_pkg::JOB_ID_W-1:0]     s_tdata,
  input  logic [pqsl_pkg::S_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pqsl_pkg::JOB_ID_W-1:0]     m_tdata,
  output logic [pqsl_pkg::M_USER_W-1:0]     m_tuser,
  input  pqsl_pkg::ctrl_cmd_t               cmd,
  output pqsl_pkg::dp_status_t              status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Queue memories and their registered read data.
  logic [pqsl_pkg::JOB_ID_W-1:0] prem_mem [QUEUE_DEPTH];
  logic [pqsl_pkg::JOB_ID_W-1:0] free_mem [QUEUE_DEPTH];
  logic [pqsl_pkg::JOB_ID_W-1:0] prem_rd;
  logic [pqsl_pkg::JOB_ID_W-1:0] free_rd;

  logic [PTR_W-1:0] prem_head, prem_head_next, prem_tail, prem_tail_next;
  logic [PTR_W-1:0] free_head, free_head_next, free_tail, free_tail_next;
  logic [CNT_W-1:0] prem_count, prem_count_next, free_count, free_count_next;
  logic [pqsl_pkg::STREAK_W-1:0] streak, streak_next;
  logic [pqsl_pkg::STREAK_W-1:0] streak_limit;

  // Extract result held for the memory read cycle.
  logic pend_valid, pend_prem, pend_empty;

  // Two-word result buffer.
  logic [pqsl_pkg::JOB_ID_W-1:0] ob_data [2];
  logic [pqsl_pkg::M_USER_W-1:0] ob_user [2];
  logic       ob_wr, ob_rd;
  logic [1:0] ob_cnt;

  logic [pqsl_pkg::FUNC_W-1:0] func;
  logic in_prem;
  logic op_insert, op_extract, op_clear;
  logic prem_full, free_full, dropped;
  logic wr_prem, wr_free, sel_prem, sel_free;
  logic all_empty_next;
  logic push, pop;
  logic [pqsl_pkg::JOB_ID_W-1:0] push_data;
  logic [pqsl_pkg::M_USER_W-1:0] push_user;

  assign func    = s_tuser[pqsl_pkg::FUNC_W-1:0];
  assign in_prem = s_tuser[pqsl_pkg::FUNC_W];

  always_comb begin
    op_insert  = cmd.accept && (func == pqsl_pkg::FUNC_INSERT);
    op_extract = cmd.accept && (func == pqsl_pkg::FUNC_EXTRACT);
    op_clear   = cmd.accept && (func == pqsl_pkg::FUNC_CLEAR);

    prem_full = (prem_count == CNT_FULL);
    free_full = (free_count == CNT_FULL);
    dropped   = in_prem ? prem_full : free_full;
    wr_prem   = op_insert && in_prem && !prem_full;
    wr_free   = op_insert && !in_prem && !free_full;

    // A waiting free job wins once the premium streak reaches the limit.
    sel_free = op_extract && (free_count != '0) &&
               ((streak >= streak_limit) || (prem_count == '0));
    sel_prem = op_extract && !sel_free && (prem_count != '0);

    prem_head_next  = prem_head;
    prem_tail_next  = prem_tail;
    prem_count_next = prem_count;
    free_head_next  = free_head;
    free_tail_next  = free_tail;
    free_count_next = free_count;
    streak_next     = streak;

    if (op_clear) begin
      prem_head_next  = '0;
      prem_tail_next  = '0;
      prem_count_next = '0;
      free_head_next  = '0;
      free_tail_next  = '0;
      free_count_next = '0;
      streak_next     = '0;
    end else begin
      if (wr_prem) begin
        prem_tail_next  = ptr_inc(prem_tail);
        prem_count_next = prem_count + 1'b1;
      end
      if (wr_free) begin
        free_tail_next  = ptr_inc(free_tail);
        free_count_next = free_count + 1'b1;
      end
      if (sel_prem) begin
        prem_head_next  = ptr_inc(prem_head);
        prem_count_next = prem_count - 1'b1;
        streak_next     = (streak == pqsl_pkg::STREAK_MAX) ? streak : streak + 1'b1;
      end
      if (sel_free) begin
        free_head_next  = ptr_inc(free_head);
        free_count_next = free_count - 1'b1;
        streak_next     = '0;
      end
    end

    all_empty_next = (prem_count_next == '0) && (free_count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prem_head    <= '0;
      prem_tail    <= '0;
      prem_count   <= '0;
      free_head    <= '0;
      free_tail    <= '0;
      free_count   <= '0;
      streak       <= '0;
      streak_limit <= pqsl_pkg::DEF_STREAK_LIMIT;
    end else begin
      prem_head  <= prem_head_next;
      prem_tail  <= prem_tail_next;
      prem_count <= prem_count_next;
      free_head  <= free_head_next;
      free_tail  <= free_tail_next;
      free_count <= free_count_next;
      streak     <= streak_next;
      if (cfg_wr_en) begin
        streak_limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_prem) begin
      prem_mem[prem_tail] <= s_tdata;
    end
    if (op_extract) begin
      prem_rd <= prem_mem[prem_head];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_free) begin
      free_mem[free_tail] <= s_tdata;
    end
    if (op_extract) begin
      free_rd <= free_mem[free_head];
    end
  end

  always_ff @(posedge clk) begin
    if (op_extract) begin
      pend_valid <= sel_prem || sel_free;
      pend_prem  <= sel_prem;
      pend_empty <= all_empty_next;
    end
  end

  // Result words: m_tuser is {all_empty, insert_dropped, out_premium, job_valid}.
  always_comb begin
    push = cmd.push_read || (cmd.accept && !op_extract);
    pop  = m_tvalid && m_tready;
    if (cmd.push_read) begin
      push_data = !pend_valid ? '0 : (pend_prem ? prem_rd : free_rd);
      push_user = {pend_empty, 1'b0, pend_prem, pend_valid};
    end else begin
      push_data = '0;
      push_user = {all_empty_next, op_insert && dropped, 1'b0, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_data[ob_wr] <= push_data;
      ob_user[ob_wr] <= push_user;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (push) begin
        ob_wr <= ~ob_wr;
      end
      if (pop) begin
        ob_rd <= ~ob_rd;
      end
      ob_cnt <= ob_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_tvalid          = (ob_cnt != 2'd0);
  assign m_tdata           = ob_data[ob_rd];
  assign m_tuser           = ob_user[ob_rd];
  assign status.out_full   = (ob_cnt == 2'd2);
  assign status.is_extract = (func == pqsl_pkg::FUNC_EXTRACT);

  `PQSL_ASSERT(a_ob_no_overflow, clk, rst, (push && !pop) |-> (ob_cnt != 2'd2), "result buffer overflow")
  `PQSL_ASSERT_ALWAYS(a_ob_cnt_range, clk, (rst || (ob_cnt != 2'd3)), "result count out of range")
  `PQSL_ASSERT(a_prem_count_range, clk, rst, (prem_count <= CNT_FULL), "premium count above depth")
  `PQSL_ASSERT(a_free_count_range, clk, rst, (free_count <= CNT_FULL), "free count above depth")
  `PQSL_ASSERT(a_free_resets_streak, clk, rst, sel_free |=> (streak == '0), "streak not cleared by free job")

endmodule

### rtl/priority_queue_starvation_limit_unit.sv
// Top level of the strict-priority job arbiter with a starvation limit.
// Instantiates pqsl_ctrl and pqsl_dp; depends on pqsl_pkg.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_tvalid / s_tready  job_id in tdata; func, is_premium in tuser
//   m_       out        m_tvalid / m_tready  out_job_id in tdata; four status flags in tuser
//   cfg_     in         cfg_wr_en            streak_limit in cfg_wr_data
//
// An insert, a clear or an unused code needs no memory read, so such words can be
// accepted back to back. An extract holds off the next word: the queue memories have
// a registered read port, and the result is formed in the cycle after the word
// is accepted. Results go through a two-word buffer, so input keeps flowing
// while a result waits; the input stalls only when that buffer is full or an
// extract read is in flight. Reset (rst, synchronous) empties both queues,
// clears the streak and sets the limit to 3; no memory clearing pass is run.
module priority_queue_starvation_limit_unit #(
  parameter int QUEUE_DEPTH = pqsl_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: streak_limit, written whenever cfg_wr_en is high.
  input  logic                              cfg_wr_en,
  input  logic [pqsl_pkg::STREAK_W-1:0]     cfg_wr_data,
  // Input words.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pqsl_pkg::JOB_ID_W-1:0]     s_tdata,  // [15:0] job_id
  input  logic [pqsl_pkg::S_USER_W-1:0]     s_tuser,  // [1:0] func, [2] is_premium
  // Result words.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pqsl_pkg::JOB_ID_W-1:0]     m_tdata,  // [15:0] out_job_id
  output logic [pqsl_pkg::M_USER_W-1:0]     m_tuser   // [0] job_valid, [1] out_premium,
                                                      // [2] insert_dropped, [3] all_empty
);

  pqsl_pkg::ctrl_cmd_t  cmd;
  pqsl_pkg::dp_status_t status;

  // The controller owns the input handshake and the extract read cycle.
  pqsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the queues, the streak and the result buffer.
  pqsl_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

### tb/sv/pqsl_checker.sv
// Checker for the job arbiter: watches the config port and both stream channels.
// It predicts every result word, compares field by field and counts failures.
// Depends on pqsl_pkg for widths, operation codes and defaults.
module pqsl_checker
  import pqsl_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [STREAK_W-1:0] cfg_wr_data,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [JOB_ID_W-1:0] s_tdata,   // [15:0] job_id
  input  logic [S_USER_W-1:0] s_tuser,   // [1:0] func, [2] is_premium
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [JOB_ID_W-1:0] m_tdata,   // [15:0] out_job_id
  input  logic [M_USER_W-1:0] m_tuser,   // [0] job_valid, [1] out_premium,
                                         // [2] insert_dropped, [3] all_empty
  output int                  fail_count,
  output int                  outstanding,
  output int                  words_checked,
  output int                  jobs_seen,
  output int                  drops_seen,
  output int                  forced_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                job_valid;
    logic [JOB_ID_W-1:0] job_id;
    logic                premium;
    logic                dropped;
    logic                all_empty;
  } job_result_t;

  logic [JOB_ID_W-1:0] prem_ring [DEPTH];
  logic [JOB_ID_W-1:0] free_ring [DEPTH];
  int unsigned         prem_head, prem_count, free_head, free_count;
  logic [STREAK_W-1:0] streak, streak_limit;
  job_result_t         awaited_q[$];
  int                  n_fail = 0, n_words = 0, n_jobs = 0, n_drops = 0, n_forced = 0;

  function automatic void clear_queues();
    prem_head  = 0;
    prem_count = 0;
    free_head  = 0;
    free_count = 0;
    streak     = '0;
  endfunction

  // Applies one accepted word to the shadow queues and returns its result.
  function automatic job_result_t serve_word(logic [FUNC_W-1:0] op, logic prem,
                                             logic [JOB_ID_W-1:0] id);
    job_result_t r;
    logic        take_free, take_prem;
    r         = '0;
    take_free = 1'b0;
    take_prem = 1'b0;
    case (op)
      FUNC_INSERT: begin
        if (prem) begin
          if (prem_count >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            prem_ring[(prem_head + prem_count) % DEPTH] = id;
            prem_count++;
          end
        end else begin
          if (free_count >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            free_ring[(free_head + free_count) % DEPTH] = id;
            free_count++;
          end
        end
      end
      FUNC_EXTRACT: begin
        // A waiting free job wins once the premium streak reaches the limit.
        if (free_count > 0 && streak >= streak_limit) begin
          take_free = 1'b1;
          if (prem_count > 0) n_forced++;
        end else if (prem_count > 0) begin
          take_prem = 1'b1;
        end else if (free_count > 0) begin
          take_free = 1'b1;
        end
        if (take_prem) begin
          r.job_id    = prem_ring[prem_head];
          r.job_valid = 1'b1;
          r.premium   = 1'b1;
          prem_head   = (prem_head + 1) % DEPTH;
          prem_count--;
          if (streak != STREAK_MAX) streak++;
        end else if (take_free) begin
          r.job_id    = free_ring[free_head];
          r.job_valid = 1'b1;
          free_head   = (free_head + 1) % DEPTH;
          free_count--;
          streak      = '0;
        end
      end
      FUNC_CLEAR: clear_queues();
      default: ;
    endcase
    r.all_empty = (prem_count == 0 && free_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    job_result_t want, got;
    if (rst) begin
      clear_queues();
      streak_limit = DEF_STREAK_LIMIT;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) streak_limit = cfg_wr_data;
      // The word is queued before the output is looked at, so a result can
      // never be matched against an older expectation by accident.
      if (s_tvalid && s_tready)
        awaited_q.push_back(serve_word(s_tuser[1:0], s_tuser[2], s_tdata));
      if (m_tvalid && m_tready) begin
        got.job_valid = m_tuser[0];
        got.job_id    = m_tdata;
        got.premium   = m_tuser[1];
        got.dropped   = m_tuser[2];
        got.all_empty = m_tuser[3];
        if (awaited_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result word with none expected: valid=%b id=%h prem=%b drop=%b %s%b",
                     $time, got.job_valid, got.job_id, got.premium, got.dropped,
                     "empty=", got.all_empty);
        end else begin
          want = awaited_q.pop_front();
          n_words++;
          if (want.job_valid) n_jobs++;
          if (want.dropped) n_drops++;
          if (got.job_valid !== want.job_valid || got.job_id !== want.job_id ||
              got.premium !== want.premium || got.dropped !== want.dropped ||
              got.all_empty !== want.all_empty) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: result %0d mismatch", $time, n_words);
              $display("  expected valid=%b id=%h prem=%b drop=%b empty=%b",
                       want.job_valid, want.job_id, want.premium,
                       want.dropped, want.all_empty);
              $display("  got      valid=%b id=%h prem=%b drop=%b empty=%b",
                       got.job_valid, got.job_id, got.premium,
                       got.dropped, got.all_empty);
            end
          end
        end
      end
    end
    fail_count    <= n_fail;
    outstanding   <= awaited_q.size();
    words_checked <= n_words;
    jobs_seen     <= n_jobs;
    drops_seen    <= n_drops;
    forced_seen   <= n_forced;
  end

endmodule

### tb/sv/tb_top.sv
// Top of the job arbiter testbench: clock, reset, stimulus and the verdict.
// Instantiates priority_queue_starvation_limit_unit and pqsl_checker;
// depends on pqsl_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pqsl_pkg::*;

  localparam int                HALF_PERIOD  = 6;
  localparam int                LIMIT_CYCLES = 400_000;
  localparam int                HOLD_CYCLES  = 160;
  // The fourth operation code has no meaning; the block must only report
  // whether both queues are empty.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [STREAK_W-1:0] cfg_wr_data = '0;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [JOB_ID_W-1:0] s_tdata     = '0;  // [15:0] job_id
  logic [S_USER_W-1:0] s_tuser     = '0;  // [1:0] func, [2] is_premium
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [JOB_ID_W-1:0] m_tdata;           // [15:0] out_job_id
  logic [M_USER_W-1:0] m_tuser;           // [0] job_valid, [1] out_premium,
                                          // [2] insert_dropped, [3] all_empty

  int fail_count, outstanding, words_checked, jobs_seen, drops_seen, forced_seen;

  // Idling switches for the sender and the receiver process.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req   = 1'b0;
  int words_sent = 0;
  int mid_limit;

  always #(HALF_PERIOD) clk = ~clk;

  priority_queue_starvation_limit_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  pqsl_checker u_checker (.*);

  // Offers one word, optionally after a random gap, and returns at the edge
  // where it was taken. tvalid stays high so the next word can follow in the
  // same step without the line dropping in between.
  task automatic send_word(input logic [FUNC_W-1:0] op, input logic prem,
                           input logic [JOB_ID_W-1:0] id);
    if (tx_idle_on && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tuser  <= {prem, op};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Stops offering words and waits until every result has been taken. The
  // first edge lets the checker count the last accepted word.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Every word gives exactly one result, so once nothing is outstanding the
  // block is idle and the limit can be changed safely.
  task automatic write_limit(input logic [STREAK_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic. The percentages set the share of inserts, of extracts
  // and of premium jobs; what is left goes to clears and the unused code,
  // or to the unused code alone where a clear would reset the streak.
  // Idling is redrawn every 64 words so quiet stretches alternate with gaps.
  task automatic run_mix(input int n, input int ins_pct, input int ext_pct,
                         input int prem_pct, input bit clr_ok, input bit idle_ok);
    logic [FUNC_W-1:0]   op;
    logic [JOB_ID_W-1:0] id;
    int                  r;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        tx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
        rx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < ins_pct)
        op = FUNC_INSERT;
      else if (r < ins_pct + ext_pct)
        op = FUNC_EXTRACT;
      else if (clr_ok && $urandom_range(0, 2) != 0)
        op = FUNC_CLEAR;
      else
        op = FUNC_UNUSED;
      case ($urandom_range(0, 15))
        0:       id = '0;
        1:       id = '1;
        default: id = JOB_ID_W'($urandom());
      endcase
      send_word(op, $urandom_range(0, 99) < prem_pct, id);
    end
  endtask

  // Receiver: ready in random stretches, stalls in random bursts while idling
  // is on, and one long hold-off on request so the result buffer fills and
  // the input side has to stall.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset limit of 3. An extract on empty queues
    // must return no job, and the unused code must only report emptiness.
    send_word(FUNC_EXTRACT, 1'b1, 16'hFFFF);
    send_word(FUNC_UNUSED, 1'b1, 16'hFFFF);
    // Two free jobs with the extreme identifiers wait behind the premium ones.
    send_word(FUNC_INSERT, 1'b0, 16'h0000);
    send_word(FUNC_INSERT, 1'b0, 16'hFFFF);
    // Seventeen premium inserts: all ones, then a walking one. The queue
    // holds sixteen, so the last one must come back flagged as dropped.
    for (int i = 0; i <= 16; i++)
      send_word(FUNC_INSERT, 1'b1, (i == 0) ? 16'hFFFF : 16'h0001 << (i - 1));
    // Three premium jobs bring the streak to the limit; the fourth extract
    // must then force out the oldest free job.
    repeat (4) send_word(FUNC_EXTRACT, 1'b0, 16'h0000);
    send_word(FUNC_CLEAR, 1'b0, 16'h0000);

    // Limit of zero: any waiting free job goes first.
    write_limit(8'h00);
    run_mix(250, 50, 42, 50, 1'b1, 1'b1);

    // Limit of 255 with premium traffic only and no clears, long enough to
    // serve well over 255 premium jobs in a row so the streak saturates.
    // The mixed tail then checks that free jobs are forced past the limit.
    write_limit(8'hFF);
    run_mix(640, 52, 47, 100, 1'b0, 1'b1);
    run_mix(60, 50, 45, 40, 1'b1, 1'b1);

    // A random limit with insert-heavy traffic so both queues fill and drop.
    mid_limit = $urandom_range(4, 254);
    write_limit(mid_limit[STREAK_W-1:0]);
    run_mix(300, 66, 30, 50, 1'b1, 1'b1);

    // Limit of one, with a long receiver hold-off in the middle while words
    // keep being offered.
    write_limit(8'h01);
    run_mix(100, 55, 42, 50, 1'b1, 1'b1);
    hold_req = 1'b1;
    run_mix(150, 55, 42, 50, 1'b1, 1'b1);

    // Last part at full rate on both sides.
    write_limit(8'h02);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_mix(200, 50, 46, 50, 1'b1, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d words under limits 3, 0, 255, %0d, 1 and 2, one long hold-off.",
             words_sent, mid_limit);
    $display("Checked %0d results: %0d jobs out, %0d drops, %0d free jobs forced.",
             words_checked, jobs_seen, drops_seen, forced_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
